// File: design/binary_to_seven_segment_digits_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef BINARY_TO_SEVEN_SEGMENT_DIGITS_ASSERT_SVH
`define BINARY_TO_SEVEN_SEGMENT_DIGITS_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B2S_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("binary_to_seven_segment_digits: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define B2S_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("binary_to_seven_segment_digits: assertion failed");

`endif

// File: design/b2s_pkg.sv
`default_nettype none

package b2s_pkg;

    localparam int VALUE_W    = 32;
    localparam int DIGIT_W    = 4;
    localparam int SEG_W      = 7;
    localparam int COUNT_W    = 4;
    localparam int MAX_DIGITS = 10;
    localparam int BCD_W      = MAX_DIGITS * DIGIT_W;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);

    // Converted value handed from the converter to the digit emitter.
    typedef struct packed {
        logic [BCD_W-1:0] bcd;
        logic             ovf;
    } b2s_bcd_t;

    // Sum-of-products segment equations, segment a on bit 0 up to g on bit 6.
    function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] dg);
        logic a;
        logic b;
        logic c;
        logic d;
        logic [SEG_W-1:0] s;
        a    = dg[3];
        b    = dg[2];
        c    = dg[1];
        d    = dg[0];
        s[0] = a | (!b & c) | (b & d) | (!b & !d);
        s[1] = !b | (!c & !d) | (c & d);
        s[2] = b | !c | d;
        s[3] = (b & !c & d) | (!b & !d) | (!b & c) | (c & !d);
        s[4] = (!b & !d) | (c & !d);
        s[5] = (!c & !d) | (b & !c) | (b & !d) | a;
        s[6] = (!b & c) | (b & !c) | a | (b & !d) | (c & !d);
        return s;
    endfunction

endpackage

`default_nettype wire

// File: design/b2s_dabble.sv
`default_nettype none

module b2s_dabble (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [b2s_pkg::VALUE_W-1:0] in_value,
    output logic                            res_valid,
    input  wire logic                       res_ready,
    output b2s_pkg::b2s_bcd_t               res
);
    import b2s_pkg::*;

    typedef enum logic [1:0] {IDLE, CONV, DONE} state_t;

    state_t                 state_reg;
    logic [VALUE_W-1:0]     shift_reg;
    logic [BCD_W-1:0]       bcd_reg;
    logic                   ovf_reg;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg;

    logic [BCD_W-1:0]       bcd_corr;
    logic [BCD_W-1:0]       bcd_next;

    // Add three to every digit of five or more, then shift in the next bit.
    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5))
                bcd_corr[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            else
                bcd_corr[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
        end
        bcd_next = {bcd_corr[BCD_W-2:0], shift_reg[VALUE_W-1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= IDLE;
            shift_reg   <= '0;
            bcd_reg     <= '0;
            ovf_reg     <= 1'b0;
            bit_cnt_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                IDLE:
                begin
                    if (in_valid)
                    begin
                        shift_reg   <= in_value;
                        bcd_reg     <= '0;
                        ovf_reg     <= 1'b0;
                        bit_cnt_reg <= '0;
                        state_reg   <= CONV;
                    end
                end
                CONV:
                begin
                    bcd_reg     <= bcd_next;
                    ovf_reg     <= ovf_reg | bcd_corr[BCD_W-1];
                    shift_reg   <= shift_reg << 1;
                    bit_cnt_reg <= bit_cnt_reg + BIT_CNT_W'(1);
                    if (bit_cnt_reg == BIT_CNT_W'(VALUE_W - 1))
                        state_reg <= DONE;
                end
                DONE:
                begin
                    if (res_ready)
                        state_reg <= IDLE;
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == IDLE);
    assign res_valid = (state_reg == DONE);
    assign res.bcd   = bcd_reg;
    assign res.ovf   = ovf_reg;

endmodule

`default_nettype wire

// File: design/b2s_emit.sv
`default_nettype none

module b2s_emit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire b2s_pkg::b2s_bcd_t           in_bcd,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [b2s_pkg::DIGIT_W-1:0]      out_digit,
    output logic [b2s_pkg::SEG_W-1:0]        out_segments,
    output logic [b2s_pkg::COUNT_W-1:0]      out_count,
    output logic                             out_last
);
    import b2s_pkg::*;

    typedef enum logic [1:0] {IDLE, SKIP, EMIT} state_t;

    state_t               state_reg;
    logic [BCD_W-1:0]     bcd_reg;
    logic                 ovf_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   rem_reg;
    logic [DIGIT_W-1:0]   top_digit;
    logic                 emit_load;

    assign top_digit = bcd_reg[BCD_W-1 -: DIGIT_W];

    // The output register takes the next digit when it is empty or being drained.
    assign emit_load = (state_reg == EMIT) && (!out_valid || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= IDLE;
            bcd_reg      <= '0;
            ovf_reg      <= 1'b0;
            count_reg    <= '0;
            rem_reg      <= '0;
            out_valid    <= 1'b0;
            out_digit    <= '0;
            out_segments <= '0;
            out_count    <= '0;
            out_last     <= 1'b0;
        end
        else
        begin
            if (emit_load)
                out_valid <= 1'b1;
            else if (out_valid && out_ready)
                out_valid <= 1'b0;
            unique case (state_reg)
                IDLE:
                begin
                    if (in_valid)
                    begin
                        bcd_reg   <= in_bcd.bcd;
                        ovf_reg   <= in_bcd.ovf;
                        count_reg <= COUNT_W'(MAX_DIGITS);
                        state_reg <= SKIP;
                    end
                end
                SKIP:
                begin
                    // Leading zeros are dropped, keeping at least one digit, unless digits were lost off the top.
                    if (!ovf_reg && top_digit == '0 && count_reg > COUNT_W'(1))
                    begin
                        bcd_reg   <= bcd_reg << DIGIT_W;
                        count_reg <= count_reg - COUNT_W'(1);
                    end
                    else
                    begin
                        rem_reg   <= count_reg;
                        state_reg <= EMIT;
                    end
                end
                EMIT:
                begin
                    if (emit_load)
                    begin
                        out_digit    <= top_digit;
                        out_segments <= seg_pattern(top_digit);
                        out_count    <= count_reg;
                        out_last     <= (rem_reg == COUNT_W'(1));
                        bcd_reg      <= bcd_reg << DIGIT_W;
                        rem_reg      <= rem_reg - COUNT_W'(1);
                        if (rem_reg == COUNT_W'(1))
                            state_reg <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign in_ready = (state_reg == IDLE);

endmodule

`default_nettype wire

// File: design/binary_to_seven_segment_digits.sv
// The double-dabble converter takes one value at a time and shifts it in one bit per cycle;
// the emitter takes the result, strips leading zeros and then emits the n remaining digits.
// A new value is converted while the previous one is still being emitted.
// Reset (rst_n, asynchronous, active low) empties both stages and clears m_tvalid.
`default_nettype none

module binary_to_seven_segment_digits (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream: one transfer per value to convert.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    // Output stream: one transfer per decimal digit, most significant first.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [3:0] digit, [10:4] segments, [14:11] digit_count,
                                        // [15] zero padding
    output logic             m_tlast    // set on the least significant digit
);
    import b2s_pkg::*;

    logic                 conv_valid;
    logic                 conv_ready;
    b2s_bcd_t             conv_res;
    logic [DIGIT_W-1:0]   digit;
    logic [SEG_W-1:0]     segments;
    logic [COUNT_W-1:0]   digit_count;

    // The converter shifts the binary value in one bit per cycle, correcting
    // every BCD digit on the way, and holds the result until the emitter takes it.
    b2s_dabble u_dabble (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata),
        .res_valid (conv_valid),
        .res_ready (conv_ready),
        .res       (conv_res)
    );

    // The emitter strips leading zeros one digit per cycle and then shifts
    // out the remaining digits through a registered output stage.
    b2s_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (conv_valid),
        .in_ready     (conv_ready),
        .in_bcd       (conv_res),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_digit    (digit),
        .out_segments (segments),
        .out_count    (digit_count),
        .out_last     (m_tlast)
    );

    // Pack the result fields from the lowest bit up; the top bit is padding.
    assign m_tdata = {1'b0, digit_count, segments, digit};

endmodule

`default_nettype wire

// File: design/b2s_checker.sv
`default_nettype none

`include "binary_to_seven_segment_digits_assert.svh"

module b2s_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tlast
);
    import b2s_pkg::*;

    // A stalled output transfer keeps its payload.
    `B2S_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // After an input transfer the converter is busy and refuses the next value.
    `B2S_ASSERT_NEXT(a_in_busy, clk, rst_n, s_tvalid && s_tready, !s_tready)

    // Every digit is a valid decimal digit.
    `B2S_ASSERT_IMPL(a_digit_range, clk, rst_n, m_tvalid, m_tdata[3:0] <= 4'd9)

    // The segment pattern always matches the digit it travels with.
    `B2S_ASSERT_IMPL(a_seg_match, clk, rst_n, m_tvalid, m_tdata[10:4] == seg_pattern(m_tdata[3:0]))

    // The digit count stays within the display positions.
    `B2S_ASSERT_IMPL(a_count_range, clk, rst_n, m_tvalid, m_tdata[14:11] >= 4'd1 && m_tdata[14:11] <= COUNT_W'(MAX_DIGITS))

endmodule

bind binary_to_seven_segment_digits b2s_checker u_b2s_checker (.*);

`default_nettype wire
